/* rtl/bba_pkg.sv */
`default_nettype none
package bba_pkg;

	// Map geometry
	localparam int MAP_WORDS      = 32;
	localparam int RESERVED_WORDS = 5;
	localparam int SYSTEM_BLOCKS  = 133;

	localparam int WORD_BITS    = 32;
	localparam int POS_W        = $clog2(WORD_BITS);
	localparam int TOTAL_BLOCKS = MAP_WORDS * WORD_BITS;
	localparam int WIDX_W       = $clog2(MAP_WORDS);
	// Block index field is 10 bits wide: only words 0..31 are reachable
	localparam int SCAN_WORDS   = (MAP_WORDS < 32) ? MAP_WORDS : 32;

	localparam int BLK_W   = 10;
	localparam int COUNT_W = 11;
	localparam int COUNT_MAX = 2047;

	localparam int INIT_FREE_RAW = (TOTAL_BLOCKS > SYSTEM_BLOCKS) ?
		(TOTAL_BLOCKS - SYSTEM_BLOCKS) : 0;
	localparam int INIT_FREE = (INIT_FREE_RAW > COUNT_MAX) ? COUNT_MAX : INIT_FREE_RAW;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [COUNT_W-1:0]   count_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_BLOCK = 2'd1,
		ST_ALREADY  = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FREE,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} scan_res_t;

endpackage
`default_nettype wire

/* rtl/bba_word_scan.sv */
`default_nettype none
// Find the first clear bit of a word, counting from the MSB.
module bba_word_scan import bba_pkg::*; (
	input  wire word_t     word,
	output scan_res_t      res,
	output word_t          word_set
);

	logic [31:0] inv;
	logic [15:0] h16;
	logic [7:0]  h8;
	logic [3:0]  h4;
	logic [1:0]  h2;
	logic [4:0]  pos;

	always_comb begin
		inv    = ~word;
		pos[4] = ~|inv[31:16];
		h16    = pos[4] ? inv[15:0] : inv[31:16];
		pos[3] = ~|h16[15:8];
		h8     = pos[3] ? h16[7:0] : h16[15:8];
		pos[2] = ~|h8[7:4];
		h4     = pos[2] ? h8[3:0] : h8[7:4];
		pos[1] = ~|h4[3:2];
		h2     = pos[1] ? h4[1:0] : h4[3:2];
		pos[0] = ~h2[1];
	end

	assign res.found = |inv;
	assign res.pos   = pos;

	// Set the found bit: position j maps to bit 31-j
	always_comb begin
		word_set = word;
		word_set[~pos] = 1'b1;
	end

endmodule
`default_nettype wire

/* rtl/bitmap_block_allocator.sv */
`default_nettype none
// Allocate scans bitmap words in S_SCAN before S_RESULT; N (1..27) is the
// number of bitmap words scanned, one word per cycle through the shared word scanner;
// allocate with an empty free counter goes straight to S_RESULT; free goes via S_FREE to S_RESULT.
// Requests: one at a time, next request taken once the result is queued;
// a stalled result beat holds the next request off for longer.
// Reset (arst_n low, asynchronous): reserved words all ones, other words clear,
// free counter at total blocks minus system blocks, no result pending.
module bitmap_block_allocator import bba_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  wire               req_type,
	input  wire  [BLK_W-1:0]  block_id,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output logic [1:0]        status,
	output logic [BLK_W-1:0]  block_index,
	output logic [COUNT_W-1:0] free_count
);

	state_t state_q, state_d;

	word_t             bitmap_q [MAP_WORDS];
	count_t            free_q;
	logic [WIDX_W-1:0] scan_q;
	logic [BLK_W-1:0]  blk_q;
	status_t           res_status_q;
	logic [BLK_W-1:0]  res_index_q;
	logic              rsp_valid_q;
	logic [1:0]        rsp_status_q;
	logic [BLK_W-1:0]  rsp_index_q;
	count_t            rsp_free_q;

	logic              accept;
	logic              slot_free;
	logic [WIDX_W-1:0] rd_idx;
	word_t             word_rd;
	word_t             word_set;
	scan_res_t         scan_res;
	logic              scan_last;
	logic              blk_bad;
	logic              blk_used;
	logic [POS_W-1:0]  bit_sel;

	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign scan_last = (scan_q == WIDX_W'(SCAN_WORDS - 1));

	// Single read port into the bitmap: free word in S_FREE, scan word otherwise
	assign rd_idx  = (state_q == S_FREE) ? WIDX_W'(blk_q >> POS_W) : scan_q;
	assign word_rd = bitmap_q[rd_idx];

	bba_word_scan u_scan (
		.word     (word_rd),
		.res      (scan_res),
		.word_set (word_set)
	);

	// Block n sits at bit 31 - (n mod 32) of its word
	assign bit_sel  = ~blk_q[POS_W-1:0];
	assign blk_bad  = (32'(blk_q) < SYSTEM_BLOCKS) || (32'(blk_q) >= TOTAL_BLOCKS);
	assign blk_used = word_rd[bit_sel];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (accept) begin
					if (req_t'(req_type) == REQ_FREE) begin
						state_d = S_FREE;
					end else if (free_q == '0 || RESERVED_WORDS >= SCAN_WORDS) begin
						state_d = S_RESULT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_res.found || scan_last) begin
					state_d = S_RESULT;
				end
			end
			S_FREE: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Bitmap and free counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++) begin
				bitmap_q[i] <= (i < RESERVED_WORDS) ? '1 : '0;
			end
			free_q <= COUNT_W'(INIT_FREE);
		end else begin
			if (state_q == S_SCAN && scan_res.found) begin
				bitmap_q[rd_idx] <= word_set;
				free_q <= (free_q != '0) ? free_q - 1'b1 : free_q;
			end
			if (state_q == S_FREE && !blk_bad && blk_used) begin
				bitmap_q[rd_idx][bit_sel] <= 1'b0;
				free_q <= (free_q != COUNT_W'(COUNT_MAX)) ? free_q + 1'b1 : free_q;
			end
		end
	end

	// Working registers: request, scan pointer, pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					blk_q        <= block_id;
					scan_q       <= WIDX_W'(RESERVED_WORDS);
					res_status_q <= ST_NO_BLOCK;
					res_index_q  <= '0;
				end
			end
			S_SCAN: begin
				if (scan_res.found) begin
					res_status_q <= ST_OK;
					res_index_q  <= BLK_W'({scan_q, scan_res.pos});
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			S_FREE: begin
				priority if (blk_bad) begin
					res_status_q <= ST_RANGE;
				end else if (!blk_used) begin
					res_status_q <= ST_ALREADY;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			S_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	// Output register: load the result beat once the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && slot_free) begin
			rsp_status_q <= res_status_q;
			rsp_index_q  <= res_index_q;
			rsp_free_q   <= free_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign block_index = rsp_index_q;
	assign free_count  = rsp_free_q;

endmodule
`default_nettype wire

/* tb/sv/bba_result_checker.sv */
`timescale 1ns / 1ps
module bba_result_checker import bba_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	input  wire               req_ready,
	input  wire               req_type,
	input  wire  [BLK_W-1:0]  block_id,
	input  wire               rsp_valid,
	input  wire               rsp_ready,
	input  wire  [1:0]        status,
	input  wire  [BLK_W-1:0]  block_index,
	input  wire  [COUNT_W-1:0] free_count,
	output int                outstanding,
	output int                fail_count
);

	typedef struct {
		status_t          status;
		logic [BLK_W-1:0] index;
		count_t           free;
	} grant_t;

	word_t  usage_map [MAP_WORDS];
	count_t free_cnt;
	grant_t grants_due [$];
	int     mismatches = 0;
	int     rsp_beats  = 0;

	function automatic void clear_map();
		for (int w = 0; w < MAP_WORDS; w++)
			usage_map[w] = (w < RESERVED_WORDS) ? '1 : '0;
		free_cnt = count_t'(INIT_FREE);
	endfunction

	// First-fit allocate or free one block; return the response this request earns.
	function automatic grant_t serve(input req_t kind, input logic [BLK_W-1:0] blk);
		grant_t g;
		bit     done;
		int     w;
		int     pos;
		g.status = ST_NO_BLOCK;
		g.index  = '0;
		done     = 1'b0;
		if (kind == REQ_ALLOC) begin
			// an empty counter refuses without looking at the map
			if (free_cnt != 0) begin
				for (int sw = RESERVED_WORDS; sw < SCAN_WORDS && !done; sw++) begin
					for (int j = 0; j < WORD_BITS && !done; j++) begin
						if (!usage_map[sw][WORD_BITS-1-j]) begin
							usage_map[sw][WORD_BITS-1-j] = 1'b1;
							if (free_cnt != 0)
								free_cnt = free_cnt - 1'b1;
							g.index  = BLK_W'(sw * WORD_BITS + j);
							g.status = ST_OK;
							done     = 1'b1;
						end
					end
				end
			end
		end else if (int'(blk) < SYSTEM_BLOCKS || int'(blk) >= TOTAL_BLOCKS) begin
			g.status = ST_RANGE;
		end else begin
			w   = int'(blk) / WORD_BITS;
			pos = WORD_BITS - 1 - int'(blk) % WORD_BITS;
			if (!usage_map[w][pos]) begin
				g.status = ST_ALREADY;
			end else begin
				usage_map[w][pos] = 1'b0;
				if (free_cnt != count_t'(COUNT_MAX))
					free_cnt = free_cnt + 1'b1;
				g.status = ST_OK;
			end
		end
		g.free = free_cnt;
		return g;
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			if (mismatches < 10)
				$display("response beat %0d: %s expected %0d, got %0d",
					rsp_beats, field, want, got);
			mismatches++;
		end
	endtask

	// Compare before predicting: a response never answers the request taken on the same edge.
	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		if (!arst_n) begin
			clear_map();
			grants_due.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (grants_due.size() == 0) begin
					if (mismatches < 10)
						$display("response beat %0d: no request waiting, got status %0d",
							rsp_beats, status);
					mismatches++;
				end else begin
					g = grants_due.pop_front();
					check_field("status", int'(g.status), int'(status));
					check_field("block_index", int'(g.index), int'(block_index));
					check_field("free_count", int'(g.free), int'(free_count));
				end
				rsp_beats++;
			end
			if (req_valid && req_ready)
				grants_due.push_back(serve(req_t'(req_type), block_id));
			outstanding <= grants_due.size();
			fail_count  <= mismatches;
		end
	end

endmodule

/* tb/sv/bitmap_block_allocator_test.sv */
`timescale 1ns / 1ps
module bitmap_block_allocator_test import bba_pkg::*;;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               req_valid    = 1'b0;
	logic               req_type     = REQ_ALLOC;
	logic [BLK_W-1:0]   block_id     = '0;
	logic               rsp_ready    = 1'b0;
	wire                req_ready;
	wire                rsp_valid;
	wire  [1:0]         status;
	wire  [BLK_W-1:0]   block_index;
	wire  [COUNT_W-1:0] free_count;
	int                 outstanding;
	int                 fail_count;

	// Percent of cycles in which each side holds off; changed per phase.
	int snd_idle_pct = 18;
	int rcv_idle_pct = 48;

	always #1 clk = ~clk;

	bitmap_block_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.block_id     (block_id),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.block_index  (block_index),
		.free_count   (free_count)
	);

	bba_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.block_id     (block_id),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.block_index  (block_index),
		.free_count   (free_count),
		.outstanding  (outstanding),
		.fail_count   (fail_count)
	);

	// Stall the response side at random; a fresh draw every cycle spreads the
	// stalls over every state of the scan and free sequences.
	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);

	// Present one request beat and hold it until the block takes it. Drop valid
	// only while idling, so valid is assigned once per edge and stays up
	// across back-to-back beats.
	task automatic send_req(input req_t kind, input logic [BLK_W-1:0] blk);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		block_id  <= blk;
		do @(posedge clk); while (!req_ready);
	endtask

	// Pick a free target: mostly inside the data area, where the bit may or
	// may not be set, sometimes anywhere so the system area gets rejected.
	function automatic logic [BLK_W-1:0] pick_free_target();
		if ($urandom_range(3) == 0)
			return BLK_W'($urandom_range(TOTAL_BLOCKS - 1));
		return BLK_W'($urandom_range(TOTAL_BLOCKS - 1, SYSTEM_BLOCKS));
	endfunction

	// Give up long after the slowest legal run would have ended.
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int phase_len [3];
		int alloc_pct;
		phase_len = '{180, 180, 170};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reject the system area at its bottom and its top edge.
		send_req(REQ_FREE, '0);
		send_req(REQ_FREE, BLK_W'(SYSTEM_BLOCKS - 1));
		// Release blocks that sit in a reserved word but above the system area:
		// they count as free, then a second release of block SYSTEM_BLOCKS reports it already free.
		send_req(REQ_FREE, BLK_W'(SYSTEM_BLOCKS));
		send_req(REQ_FREE, BLK_W'(SYSTEM_BLOCKS));
		send_req(REQ_FREE, BLK_W'(RESERVED_WORDS * WORD_BITS - 1));
		// Allocate ignores block_id; the scan skips the reserved words, so the
		// first fit lands at the start of the data area.
		send_req(REQ_ALLOC, '1);
		send_req(REQ_ALLOC, 10'h2AA);
		send_req(REQ_ALLOC, 10'h155);
		send_req(REQ_ALLOC, '0);
		// Top block and alternating patterns, all still unallocated.
		send_req(REQ_FREE, '1);
		send_req(REQ_FREE, 10'h2AA);
		send_req(REQ_FREE, 10'h155);
		// Free the first data-area block and take it back.
		send_req(REQ_FREE, BLK_W'(RESERVED_WORDS * WORD_BITS));
		send_req(REQ_FREE, BLK_W'(RESERVED_WORDS * WORD_BITS));
		send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, BLK_W'(RESERVED_WORDS * WORD_BITS + 1));
		send_req(REQ_ALLOC, '1);

		// Random: allocation-heavy so the map fills word by word and the scan
		// grows long; then churn with a mix of allocates and frees.
		// The free counter always stays above the number of clear bits here,
		// so an empty counter cannot occur with this geometry.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					snd_idle_pct = 18;
					rcv_idle_pct = 48;
				end
				1: begin
					snd_idle_pct = 48;
					rcv_idle_pct = 18;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < phase_len[ph]; n++) begin
				alloc_pct = (ph < 2) ? 96 : ((n < 60) ? 98 : 50);
				if ($urandom_range(99) < alloc_pct)
					send_req(REQ_ALLOC, BLK_W'($urandom_range(TOTAL_BLOCKS - 1)));
				else
					send_req(REQ_FREE, pick_free_target());
			end
		end
		req_valid <= 1'b0;

		// Drain: let the checker register the last beat, wait for every
		// response, then allow a full scan's worth of quiet cycles.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
